>>> rtl/mwac_pkg.sv
`timescale 1ns / 1ps
package mwac_pkg;

	localparam int MAX_LEN_DEF     = 4096;
	localparam int MAX_COLOURS_DEF = 256;
	localparam int COLOUR_W        = 9;
	localparam int POS_W           = 13;

	localparam logic [COLOUR_W-1:0] NUM_COLORS_RESET = COLOUR_W'(1);

	typedef struct packed {
		logic [COLOUR_W-1:0] colour;
		logic                last;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] start_pos;
		logic [POS_W-1:0] end_pos;
	} out_item_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic inc;
		logic check;
		logic lrd;
		logic dec;
		logic finish;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic counted;
		logic loop_go;
		logic out_idx_zero;
		logic last;
		logic out_free;
	} dp_sts_t;

endpackage

>>> rtl/min_window_all_colors.sv
`timescale 1ns / 1ps
// Shortest window holding every colour 1..num_colors.
//
// Requests enter on in_valid/in_stall with in_data (colour, last); one request
// is taken at an edge with in_valid high and in_stall low. Results leave on
// out_valid/out_stall with out_data (found, start_pos, end_pos), one per
// sequence, after the request that carries last. Positions are 1-based; when
// no window covers, found, start_pos and end_pos are all zero.
// num_colors is written on cfg_valid/cfg_ready/cfg_data; the user must write
// it only while the block idles, and the block itself does not enforce this.
//
// Each request passes through take, count (only when its colour is counted)
// and check; every step of the left edge of the window adds a left read and,
// for a counted colour, an uncount. Left steps are bounded by the items taken;
// the count read-modify-write through the registered-read memory sets the pace
// of these steps. The finish step after the last request raises out_valid.
// Reset clears the counts, pointers and output valid; num_colors returns to 1.
// A stalled result holds in the output register; the block keeps taking
// requests and only waits when a second result is ready behind it.
module min_window_all_colors #(
	parameter int MAX_LEN     = mwac_pkg::MAX_LEN_DEF,
	parameter int MAX_COLOURS = mwac_pkg::MAX_COLOURS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mwac_pkg::COLOUR_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  mwac_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mwac_pkg::out_item_t           out_data
);

	mwac_pkg::dp_cmd_t cmd;
	mwac_pkg::dp_sts_t sts;

	// The register takes a write in any cycle
	assign cfg_ready = 1'b1;

	// Sequence the pointer moves: take, count, check, read left, uncount, finish
	mwac_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Hold the element buffer, colour counts, pointers, best window and result
	mwac_dp #(
		.MAX_LEN    (MAX_LEN),
		.MAX_COLOURS(MAX_COLOURS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

>>> rtl/mwac_ram.sv
`timescale 1ns / 1ps
module mwac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/mwac_ctrl.sv
`timescale 1ns / 1ps
module mwac_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mwac_pkg::dp_sts_t sts,
	output mwac_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_INC    = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_LRD    = 3'd3;
	localparam logic [2:0] S_DEC    = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.inc    = (state_q == S_INC);
		cmd.check  = (state_q == S_CHECK) && sts.loop_go;
		cmd.lrd    = (state_q == S_LRD);
		cmd.dec    = (state_q == S_DEC);
		cmd.finish = (state_q == S_FINISH) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = sts.counted ? S_INC : S_CHECK;
				end
			end
			S_INC: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.loop_go) begin
					state_d = S_LRD;
				end else if (sts.last) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LRD: begin
				state_d = sts.out_idx_zero ? S_CHECK : S_DEC;
			end
			S_DEC: begin
				state_d = S_CHECK;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/mwac_dp.sv
`timescale 1ns / 1ps
module mwac_dp #(
	parameter int MAX_LEN     = mwac_pkg::MAX_LEN_DEF,
	parameter int MAX_COLOURS = mwac_pkg::MAX_COLOURS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [mwac_pkg::COLOUR_W-1:0]   cfg_data,
	input  mwac_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output mwac_pkg::out_item_t             out_data,
	input  mwac_pkg::dp_cmd_t               cmd,
	output mwac_pkg::dp_sts_t               sts
);

	localparam int PW = $clog2(MAX_LEN + 1);
	localparam int BW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_COLOURS + 1);
	localparam int AW = (MAX_COLOURS > 1) ? $clog2(MAX_COLOURS) : 1;

	logic [mwac_pkg::COLOUR_W-1:0] num_colors_q;
	logic [CW-1:0]                 idx_q;
	logic                          last_q;
	logic                          skip_q;
	logic [PW-1:0]                 right_q;
	logic [PW-1:0]                 left_q;
	logic [CW-1:0]                 covered_q;
	logic                          best_found_q;
	logic [PW-1:0]                 best_len_q;
	logic [PW-1:0]                 best_start_q;
	logic [PW-1:0]                 best_end_q;
	logic [AW-1:0]                 dec_addr_q;
	logic [MAX_COLOURS-1:0]        cnt_vld_q;
	logic                          out_valid_q;
	mwac_pkg::out_item_t           out_data_q;

	logic          room;
	logic          counted_in;
	logic [CW-1:0] idx_in;
	logic [CW-1:0] buf_rdata;
	logic [PW-1:0] cnt_rdata;
	logic [PW-1:0] cnt_cur;
	logic [AW-1:0] inc_addr;
	logic [AW-1:0] rmw_addr;
	logic [AW-1:0] cnt_raddr;
	logic          cnt_we;
	logic [PW-1:0] cnt_wdata;
	logic [PW-1:0] win_len;
	logic          better;
	logic          out_free;

	// Colour 0 and colours above the limits take a position but count nowhere
	assign room       = (right_q < PW'(MAX_LEN));
	assign counted_in = (in_data.colour != '0) && (in_data.colour <= num_colors_q)
		&& (32'(in_data.colour) <= 32'(MAX_COLOURS));
	assign idx_in     = counted_in ? CW'(in_data.colour) : '0;

	assign inc_addr  = AW'(idx_q - CW'(1));
	assign rmw_addr  = cmd.inc ? inc_addr : dec_addr_q;
	assign cnt_cur   = cnt_vld_q[rmw_addr] ? cnt_rdata : '0;
	assign cnt_raddr = cmd.accept ? AW'(idx_in - CW'(1)) : AW'(buf_rdata - CW'(1));
	assign cnt_we    = cmd.inc || (cmd.dec && (cnt_cur != '0));
	assign cnt_wdata = cmd.inc ? (cnt_cur + PW'(1)) : (cnt_cur - PW'(1));

	assign win_len = right_q - left_q;
	assign better  = !best_found_q || (win_len < best_len_q);

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sts              = '0;
		sts.counted      = room && counted_in;
		sts.loop_go      = !skip_q && (left_q < right_q)
			&& (32'(covered_q) >= 32'(num_colors_q));
		sts.out_idx_zero = (buf_rdata == '0);
		sts.last         = last_q;
		sts.out_free     = out_free;
	end

	mwac_ram #(
		.WIDTH(CW),
		.DEPTH(MAX_LEN)
	) u_buf (
		.clk  (clk),
		.we   (cmd.accept && room),
		.waddr(right_q[BW-1:0]),
		.wdata(idx_in),
		.raddr(left_q[BW-1:0]),
		.rdata(buf_rdata)
	);

	mwac_ram #(
		.WIDTH(PW),
		.DEPTH(MAX_COLOURS)
	) u_cnt (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(rmw_addr),
		.wdata(cnt_wdata),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_colors_q <= mwac_pkg::NUM_COLORS_RESET;
			last_q       <= 1'b0;
			skip_q       <= 1'b0;
			right_q      <= '0;
			left_q       <= '0;
			covered_q    <= '0;
			best_found_q <= 1'b0;
			cnt_vld_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				num_colors_q <= cfg_data;
			end
			if (cmd.accept) begin
				last_q <= in_data.last;
				skip_q <= !room;
				if (room) begin
					right_q <= right_q + PW'(1);
				end
			end
			if (cmd.inc) begin
				if (cnt_cur == '0) begin
					covered_q <= covered_q + CW'(1);
				end
				cnt_vld_q[rmw_addr] <= 1'b1;
			end
			if (cmd.check && better) begin
				best_found_q <= 1'b1;
			end
			if (cmd.lrd && (buf_rdata == '0)) begin
				left_q <= left_q + PW'(1);
			end
			if (cmd.dec) begin
				if ((cnt_cur == PW'(1)) && (covered_q != '0)) begin
					covered_q <= covered_q - CW'(1);
				end
				left_q <= left_q + PW'(1);
			end
			// Drop the delivered result, load a new one, clear the sequence
			if (cmd.finish) begin
				out_valid_q  <= 1'b1;
				right_q      <= '0;
				left_q       <= '0;
				covered_q    <= '0;
				best_found_q <= 1'b0;
				cnt_vld_q    <= '0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q <= idx_in;
		end
		if (cmd.check && better) begin
			best_len_q   <= win_len;
			best_start_q <= left_q + PW'(1);
			best_end_q   <= right_q;
		end
		if (cmd.lrd) begin
			dec_addr_q <= AW'(buf_rdata - CW'(1));
		end
		if (cmd.finish) begin
			out_data_q.found     <= best_found_q;
			out_data_q.start_pos <= best_found_q ? mwac_pkg::POS_W'(best_start_q) : '0;
			out_data_q.end_pos   <= best_found_q ? mwac_pkg::POS_W'(best_end_q) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> rtl/mwac_check.sv
`timescale 1ns / 1ps
module mwac_check (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input mwac_pkg::out_item_t out_data
);

	// A stalled result stays in place
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// A miss reports zero positions
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> (out_data.start_pos == '0) && (out_data.end_pos == '0))
		else $error("miss with nonzero positions");

	// The block is busy in the cycle after it takes a request
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken on consecutive cycles");

	// A new result follows the finishing cycle, when requests are held off
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a finishing cycle");

endmodule

bind min_window_all_colors mwac_check u_mwac_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);

>>> tb/mwac_window_check.sv
`timescale 1ns / 1ps
module mwac_window_check #(
	parameter int MAX_LEN     = mwac_pkg::MAX_LEN_DEF,
	parameter int MAX_COLOURS = mwac_pkg::MAX_COLOURS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [mwac_pkg::COLOUR_W-1:0] cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  mwac_pkg::in_item_t            in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  mwac_pkg::out_item_t           out_data,
	output int unsigned                   errors = 0,
	output int unsigned                   waiting = 0
);
	import mwac_pkg::*;

	localparam int unsigned NO_WINDOW = 32'hFFFF_FFFF;

	logic [COLOUR_W-1:0] need;
	logic [COLOUR_W-1:0] slot_id [MAX_LEN];
	int unsigned         tally [MAX_COLOURS+1];
	int unsigned         covered, lo, hi;
	int unsigned         best_len, best_lo, best_hi;
	out_item_t           expected_windows [$];
	out_item_t           want;

	task clear_window();
		for (int i = 0; i <= MAX_COLOURS; i++)
			tally[i] = 0;
		covered  = 0;
		lo       = 0;
		hi       = 0;
		best_len = NO_WINDOW;
		best_lo  = 0;
		best_hi  = 0;
	endtask

	// Slide the right edge over one colour, then shrink from the left while covered.
	task absorb_colour(input logic [COLOUR_W-1:0] c);
		logic [COLOUR_W-1:0] id;
		logic [COLOUR_W-1:0] gone;
		id = '0;
		if (hi < MAX_LEN) begin
			if (c >= 1 && c <= need && c <= MAX_COLOURS)
				id = c;
			slot_id[hi] = id;
			hi++;
			if (id != 0) begin
				if (tally[id] == 0)
					covered++;
				tally[id]++;
			end
			while (lo < hi && covered >= need) begin
				if (hi - lo < best_len) begin
					best_len = hi - lo;
					best_lo  = lo + 1;
					best_hi  = hi;
				end
				gone = slot_id[lo];
				if (gone != 0 && tally[gone] != 0) begin
					tally[gone]--;
					if (tally[gone] == 0 && covered != 0)
						covered--;
				end
				lo++;
			end
		end
	endtask

	function out_item_t window_result();
		out_item_t r;
		r = '0;
		if (best_len != NO_WINDOW) begin
			r.found     = 1'b1;
			r.start_pos = POS_W'(best_lo);
			r.end_pos   = POS_W'(best_hi);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need = NUM_COLORS_RESET;
			clear_window();
			expected_windows.delete();
			waiting = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				need = cfg_data;
			if (out_valid && !out_stall) begin
				if (expected_windows.size() == 0) begin
					errors++;
					$error("result with no sequence pending: found=%0d start_pos=%0d end_pos=%0d",
						out_data.found, out_data.start_pos, out_data.end_pos);
				end else begin
					want = expected_windows.pop_front();
					if (out_data.found !== want.found) begin
						errors++;
						$error("found: expected %0d, actual %0d", want.found, out_data.found);
					end
					if (out_data.start_pos !== want.start_pos) begin
						errors++;
						$error("start_pos: expected %0d, actual %0d",
							want.start_pos, out_data.start_pos);
					end
					if (out_data.end_pos !== want.end_pos) begin
						errors++;
						$error("end_pos: expected %0d, actual %0d",
							want.end_pos, out_data.end_pos);
					end
				end
			end
			if (in_valid && !in_stall) begin
				absorb_colour(in_data.colour);
				if (in_data.last) begin
					expected_windows.push_back(window_result());
					clear_window();
				end
			end
			waiting = expected_windows.size();
		end
	end

endmodule

>>> tb/tb_min_window_all_colors.sv
`timescale 1ns / 1ps
module tb_min_window_all_colors;
	import mwac_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [COLOUR_W-1:0] cfg_data;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_data;
	logic                out_valid;
	logic                out_stall;
	out_item_t           out_data;
	int unsigned         errors;
	int unsigned         waiting;

	// Calm stretches: no source gaps and no sink stalls.
	bit                  calm;
	// Colours of the sequence about to be sent.
	logic [COLOUR_W-1:0] colours_q [$];

	min_window_all_colors u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	mwac_window_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.errors    (errors),
		.waiting   (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far above the slowest legal run.
	initial begin
		#8_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Result sink: stall mostly in short bursts, now and then for a long stretch,
	// and never while calm.
	initial begin : result_sink
		int unsigned hold;
		int unsigned r;
		out_stall = 1'b0;
		hold      = 0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				hold--;
			end else begin
				r = $urandom_range(0, 99);
				if (calm || r < 60) begin
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b1;
					hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				end
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// Offer one request and hold it until taken. Valid stays high into the next
	// request when no gap falls between them.
	task automatic push_item(input logic [COLOUR_W-1:0] c, input logic l);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		in_data.colour <= c;
		in_data.last   <= l;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid, then wait until every pending result has come out.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (waiting != 0) @(negedge clk);
	endtask

	// Write num_colors with the block idle; allow time for any trailing left
	// steps after the last request before raising the write.
	task automatic write_need(input logic [COLOUR_W-1:0] v);
		drain();
		repeat (64) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Send the queued colours; flag the final one as last when asked.
	task automatic send_sequence(input bit close);
		for (int i = 0; i < colours_q.size(); i++)
			push_item(colours_q[i], close && (i == colours_q.size() - 1));
	endtask

	function automatic logic [COLOUR_W-1:0] near_colour(input int unsigned need);
		if ($urandom_range(0, 99) < 85)
			return COLOUR_W'($urandom_range(1, need));
		else if ($urandom_range(0, 1) == 0)
			return '0;
		else
			return COLOUR_W'($urandom_range(need + 1, 511));
	endfunction

	// Build one sequence. A clean one hides every needed colour, shuffled, among
	// repeats and stray colours; a broken one is plain noise over the full range.
	task automatic build_sequence(input int unsigned need, input bit clean);
		int unsigned perm [$];
		int unsigned j;
		int unsigned t;
		colours_q.delete();
		if (!clean || need == 0 || need > MAX_COLOURS_DEF) begin
			repeat ($urandom_range(1, 10))
				colours_q.push_back(COLOUR_W'($urandom_range(0, 511)));
		end else begin
			for (int i = 1; i <= need; i++)
				perm.push_back(i);
			for (int i = need - 1; i > 0; i--) begin
				j       = $urandom_range(0, i);
				t       = perm[i];
				perm[i] = perm[j];
				perm[j] = t;
			end
			repeat ($urandom_range(0, 3))
				colours_q.push_back(near_colour(need));
			foreach (perm[i]) begin
				colours_q.push_back(COLOUR_W'(perm[i]));
				if ($urandom_range(0, 4) == 0)
					colours_q.push_back(near_colour(need));
			end
			repeat ($urandom_range(0, 2))
				colours_q.push_back(near_colour(need));
		end
	endtask

	// One setting of num_colors, then sequences until the request budget is spent.
	task automatic run_phase(input int unsigned need, input int unsigned budget,
		input bit only_clean);
		int unsigned sent;
		write_need(COLOUR_W'(need));
		calm = ($urandom_range(0, 3) == 0);
		sent = 0;
		while (sent < budget) begin
			build_sequence(need, only_clean || $urandom_range(0, 99) >= 15);
			send_sequence(1'b1);
			sent += colours_q.size();
			// Hold the source now and then until the sink has caught up.
			if ($urandom_range(0, 7) == 0)
				drain();
		end
	endtask

	initial begin : stimulus
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		calm      = 1'b0;
		arst_n    = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Reset value of num_colors: a single request forms a window of one.
		colours_q = '{1};
		send_sequence(1'b1);
		// Colour zero and the all-ones colour count toward nothing.
		colours_q = '{0, 511};
		send_sequence(1'b1);

		// Two equally short windows: keep the leftmost.
		write_need(3);
		colours_q = '{1, 2, 3, 3, 1, 2};
		send_sequence(1'b1);
		// Colours above num_colors still take a position.
		colours_q = '{257, 1, 256, 2, 3};
		send_sequence(1'b1);

		// No colours needed: the first request already covers.
		write_need(0);
		colours_q = '{5, 7};
		send_sequence(1'b1);

		// Change num_colors inside a sequence: colour 3 arrived uncounted and stays so.
		write_need(2);
		colours_q = '{1, 3};
		send_sequence(1'b0);
		write_need(3);
		colours_q = '{2};
		send_sequence(1'b1);

		// Need above the number of colours that exist: never found.
		write_need(511);
		colours_q = '{1, 2, 300};
		send_sequence(1'b1);

		run_phase(2, 30, 1'b0);
		run_phase(5, 30, 1'b0);
		run_phase(1, 20, 1'b0);
		run_phase(0, 20, 1'b0);
		run_phase(300, 20, 1'b0);
		run_phase(8, 30, 1'b0);
		run_phase(256, 1, 1'b1);
		run_phase(3, 30, 1'b0);
		run_phase(511, 15, 1'b0);

		drain();
		repeat (50) @(negedge clk);
		if (errors == 0 && waiting == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
